/* hdl/newline_record_blocker_core_assert.svh */
// ----------------------------------------------------------------------------
// newline_record_blocker_core_assert.svh
// Assertion macros used by the record blocker checker.
// ----------------------------------------------------------------------------
`ifndef NEWLINE_RECORD_BLOCKER_CORE_ASSERT_SVH
`define NEWLINE_RECORD_BLOCKER_CORE_ASSERT_SVH

// same-cycle implication, reset masked
`define NRB_AS_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define NRB_AS_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/nrb_pkg.sv */
// ----------------------------------------------------------------------------
// nrb_pkg
// Types and constants of the newline record blocker.
// ----------------------------------------------------------------------------
package nrb_pkg;

    localparam int MaxRecLen = 4096;

    localparam int LenW   = 13;
    localparam int TruncW = 32;
    localparam int ByteW  = 8;

    localparam logic [ByteW-1:0] NlByte = 8'h0A;
    localparam logic [ByteW-1:0] SpByte = 8'h20;

    localparam logic [LenW-1:0] RecLenReset = 13'd80;

    typedef enum logic [1:0] {
        REQ_DATA = 2'd0,
        REQ_EOI  = 2'd1,
        REQ_TBL  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        MODE_FILL = 2'd0,
        MODE_FULL = 2'd1,
        MODE_SKIP = 2'd2
    } t_mode;

    typedef enum logic {
        CFG_REC_LEN = 1'b0,
        CFG_XLAT_EN = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [ByteW-1:0]  out_byte;
        logic              use_xlat;
        logic [LenW-1:0]   repeat_count;
        logic              record_end;
        logic              end_of_input;
        logic [TruncW-1:0] trunc;
    } t_res;

endpackage

/* hdl/nrb_ram.sv */
// ----------------------------------------------------------------------------
// nrb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/nrb_step.sv */
// ----------------------------------------------------------------------------
// nrb_step
// Record state, config registers and the first result stage.
// ----------------------------------------------------------------------------
module nrb_step (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [nrb_pkg::LenW-1:0]  i_cfg_wdata,
    input  logic                      i_accept,
    input  logic                      i_adv,
    input  logic [1:0]                i_req,
    input  logic [nrb_pkg::ByteW-1:0] i_byte,
    output logic                      o_s1_valid,
    output nrb_pkg::t_res             o_s1
);

    logic [nrb_pkg::LenW-1:0]   r_rec_len;
    logic                       r_xlat_en;
    logic [nrb_pkg::LenW-1:0]   r_column, n_column;
    nrb_pkg::t_mode             r_mode, n_mode;
    logic [nrb_pkg::TruncW-1:0] r_trunc, n_trunc;
    logic                       r_s1_valid;
    nrb_pkg::t_res              r_s1;

    logic [nrb_pkg::LenW-1:0]   w_len;
    logic [nrb_pkg::LenW-1:0]   w_pad;
    logic [nrb_pkg::LenW-1:0]   w_col_inc;
    logic [nrb_pkg::TruncW-1:0] w_trunc_inc;
    logic                       w_is_nl;
    logic                       w_partial;
    logic                       w_rec_full;
    logic                       w_has;
    nrb_pkg::t_res              w_res;

    always_comb begin
        if (r_rec_len == '0) begin
            w_len = nrb_pkg::LenW'(1);
        end else if (32'(r_rec_len) > nrb_pkg::MaxRecLen) begin
            w_len = nrb_pkg::LenW'(nrb_pkg::MaxRecLen);
        end else begin
            w_len = r_rec_len;
        end
    end

    assign w_pad       = (r_column < w_len) ? (w_len - r_column) : '0;
    assign w_col_inc   = r_column + nrb_pkg::LenW'(1);
    assign w_trunc_inc = (r_trunc == '1) ? r_trunc : (r_trunc + nrb_pkg::TruncW'(1));
    assign w_is_nl     = (i_byte == nrb_pkg::NlByte);
    assign w_partial   = (r_mode == nrb_pkg::MODE_FILL) && (r_column != '0);
    assign w_rec_full  = (w_col_inc >= w_len) || (w_col_inc == '0);

    // next mode
    always_comb begin
        n_mode = r_mode;
        if (i_accept) begin
            unique case (i_req)
                nrb_pkg::REQ_DATA: begin
                    unique case (r_mode)
                        nrb_pkg::MODE_FULL: begin
                            n_mode = w_is_nl ? nrb_pkg::MODE_FILL : nrb_pkg::MODE_SKIP;
                        end
                        nrb_pkg::MODE_SKIP: begin
                            n_mode = w_is_nl ? nrb_pkg::MODE_FILL : nrb_pkg::MODE_SKIP;
                        end
                        default: begin
                            n_mode = (!w_is_nl && w_rec_full) ? nrb_pkg::MODE_FULL
                                                              : nrb_pkg::MODE_FILL;
                        end
                    endcase
                end
                nrb_pkg::REQ_EOI: n_mode = nrb_pkg::MODE_FILL;
                default:          n_mode = r_mode;
            endcase
        end
    end

    // column, count and result
    always_comb begin
        n_column           = r_column;
        n_trunc            = r_trunc;
        w_has              = 1'b0;
        w_res.out_byte     = i_byte;
        w_res.use_xlat     = r_xlat_en;
        w_res.repeat_count = nrb_pkg::LenW'(1);
        w_res.record_end   = 1'b0;
        w_res.end_of_input = 1'b0;
        w_res.trunc        = r_trunc;
        if (i_accept) begin
            unique case (i_req)
                nrb_pkg::REQ_DATA: begin
                    unique case (r_mode)
                        nrb_pkg::MODE_FULL: begin
                            if (!w_is_nl) begin
                                n_trunc = w_trunc_inc;
                            end
                        end
                        nrb_pkg::MODE_SKIP: begin
                            n_trunc = r_trunc;
                        end
                        default: begin
                            w_has = 1'b1;
                            if (w_is_nl) begin
                                w_res.out_byte     = nrb_pkg::SpByte;
                                w_res.repeat_count = w_pad;
                                w_res.record_end   = 1'b1;
                                n_column           = '0;
                            end else if (w_rec_full) begin
                                w_res.record_end = 1'b1;
                                n_column         = '0;
                            end else begin
                                n_column = w_col_inc;
                            end
                        end
                    endcase
                end
                nrb_pkg::REQ_EOI: begin
                    w_has              = 1'b1;
                    w_res.end_of_input = 1'b1;
                    w_res.record_end   = w_partial;
                    w_res.use_xlat     = r_xlat_en && w_partial;
                    w_res.out_byte     = w_partial ? nrb_pkg::SpByte : '0;
                    w_res.repeat_count = w_partial ? w_pad : '0;
                    w_res.trunc        = w_partial ? w_trunc_inc : r_trunc;
                    n_trunc            = '0;
                    n_column           = '0;
                end
                default: begin
                    w_has = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_len <= nrb_pkg::RecLenReset;
            r_xlat_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                nrb_pkg::CFG_REC_LEN: r_rec_len <= i_cfg_wdata;
                nrb_pkg::CFG_XLAT_EN: r_xlat_en <= i_cfg_wdata[0];
                default:              r_rec_len <= r_rec_len;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column   <= '0;
            r_mode     <= nrb_pkg::MODE_FILL;
            r_trunc    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_column <= n_column;
            r_mode   <= n_mode;
            r_trunc  <= n_trunc;
            if (i_adv) begin
                r_s1_valid <= w_has;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1 <= w_res;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule

/* hdl/nrb_outreg.sv */
// ----------------------------------------------------------------------------
// nrb_outreg
// Final byte select and output register of the result stream.
// ----------------------------------------------------------------------------
module nrb_outreg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s1_valid,
    input  nrb_pkg::t_res              i_s1,
    input  logic [nrb_pkg::ByteW-1:0]  i_xlat_q,
    input  logic                       i_ready,
    output logic                       o_free,
    output logic                       o_valid,
    output logic [nrb_pkg::ByteW-1:0]  o_byte,
    output logic [nrb_pkg::LenW-1:0]   o_repeat,
    output logic                       o_record_end,
    output logic                       o_eoi,
    output logic [nrb_pkg::TruncW-1:0] o_trunc
);

    logic                       r_valid;
    logic [nrb_pkg::ByteW-1:0]  r_byte;
    logic [nrb_pkg::LenW-1:0]   r_repeat;
    logic                       r_record_end;
    logic                       r_eoi;
    logic [nrb_pkg::TruncW-1:0] r_trunc;
    logic                       w_free;

    assign w_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_free) begin
            r_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            r_byte       <= i_s1.use_xlat ? i_xlat_q : i_s1.out_byte;
            r_repeat     <= i_s1.repeat_count;
            r_record_end <= i_s1.record_end;
            r_eoi        <= i_s1.end_of_input;
            r_trunc      <= i_s1.trunc;
        end
    end

    assign o_free       = w_free;
    assign o_valid      = r_valid;
    assign o_byte       = r_byte;
    assign o_repeat     = r_repeat;
    assign o_record_end = r_record_end;
    assign o_eoi        = r_eoi;
    assign o_trunc      = r_trunc;

endmodule

/* hdl/newline_record_blocker_core.sv */
// ----------------------------------------------------------------------------
// newline_record_blocker_core
// Newline-terminated byte stream to fixed-length records.
// ----------------------------------------------------------------------------
// Input beats carry a request kind on tuser (data byte, end of input, table
// write) and {table_index, data_byte} on tdata. Each data byte gives one
// output beat of a byte and a repeat count; a newline gives one pad run
// that fills the record; end of input gives one beat that also reports the
// truncation total and clears it. Table writes, bytes being discarded and a
// newline right after a full record give no output beat.
// Throughput is one input beat per clock unless the output stalls. An
// accepted beat passes the first stage (state update, table RAM read),
// then the output register. The user is to write config (record
// length, translate enable) through i_cfg_* only while the block is idle;
// the block does not enforce this. Reset clears the record state and total
// and restores record length 80 with translation off; the table is not
// cleared. When the receiver stalls, the output register holds and the
// two stages fill up; tready drops once both are occupied and the output is stalled.
// ----------------------------------------------------------------------------
module newline_record_blocker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [12:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [7:0] data_byte, [15:8] table_index
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // [7:0] out_byte, [20:8] repeat_count,
                                          // [52:21] truncated_records, [55:53] zero
    output logic        o_m_axis_tlast,   // record_end
    output logic        o_m_axis_tuser    // end_of_input
);

    logic                       w_accept;
    logic                       w_adv;
    logic                       w_out_free;
    logic                       w_s1_valid;
    nrb_pkg::t_res              w_s1;
    logic [nrb_pkg::ByteW-1:0]  w_xlat_q;
    logic [nrb_pkg::ByteW-1:0]  w_raddr;
    logic                       w_tbl_we;
    logic [nrb_pkg::ByteW-1:0]  w_out_byte;
    logic [nrb_pkg::LenW-1:0]   w_out_rep;
    logic [nrb_pkg::TruncW-1:0] w_out_trunc;

    assign w_adv           = !w_s1_valid || w_out_free;
    assign o_s_axis_tready = w_adv;
    assign w_accept        = i_s_axis_tvalid && w_adv;

    assign w_tbl_we = w_accept && (i_s_axis_tuser == nrb_pkg::REQ_TBL);
    assign w_raddr  = ((i_s_axis_tuser == nrb_pkg::REQ_DATA)
                       && (i_s_axis_tdata[7:0] != nrb_pkg::NlByte))
                      ? i_s_axis_tdata[7:0] : nrb_pkg::SpByte;

    nrb_ram #(
        .WIDTH (nrb_pkg::ByteW),
        .DEPTH (256)
    ) u_xlat (
        .i_clk   (i_clk),
        .i_we    (w_tbl_we),
        .i_waddr (i_s_axis_tdata[15:8]),
        .i_wdata (i_s_axis_tdata[7:0]),
        .i_re    (w_accept),
        .i_raddr (w_raddr),
        .o_rdata (w_xlat_q)
    );

    nrb_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .i_adv       (w_adv),
        .i_req       (i_s_axis_tuser),
        .i_byte      (i_s_axis_tdata[7:0]),
        .o_s1_valid  (w_s1_valid),
        .o_s1        (w_s1)
    );

    nrb_outreg u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s1_valid   (w_s1_valid),
        .i_s1         (w_s1),
        .i_xlat_q     (w_xlat_q),
        .i_ready      (i_m_axis_tready),
        .o_free       (w_out_free),
        .o_valid      (o_m_axis_tvalid),
        .o_byte       (w_out_byte),
        .o_repeat     (w_out_rep),
        .o_record_end (o_m_axis_tlast),
        .o_eoi        (o_m_axis_tuser),
        .o_trunc      (w_out_trunc)
    );

    assign o_m_axis_tdata = {3'b000, w_out_trunc, w_out_rep, w_out_byte};

endmodule

/* hdl/nrb_checker.sv */
// ----------------------------------------------------------------------------
// nrb_checker
// Port-level checks of the record blocker, bound to the top level.
// ----------------------------------------------------------------------------
`include "newline_record_blocker_core_assert.svh"

module nrb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [55:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic        o_m_axis_tuser
);

    logic [12:0] w_rep;
    logic        w_stall;
    logic        w_beat;

    assign w_rep   = o_m_axis_tdata[20:8];
    assign w_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_beat  = o_m_axis_tvalid;

    // stalled output beat holds
    `NRB_AS_NXT(a_hold, i_clk, i_rst_n, w_stall, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stall")

    // mid-record data beat is a single byte
    `NRB_AS_IMP(a_single, i_clk, i_rst_n, w_beat && !o_m_axis_tuser && !o_m_axis_tlast, w_rep == 13'd1, "rep")

    // end of input with nothing pending pads nothing
    `NRB_AS_IMP(a_eoi_empty, i_clk, i_rst_n, w_beat && o_m_axis_tuser && !o_m_axis_tlast, w_rep == '0, "eoi")

    // a run never exceeds the longest record
    `NRB_AS_IMP(a_rep_max, i_clk, i_rst_n, w_beat, 32'(w_rep) <= nrb_pkg::MaxRecLen, "len")

endmodule

bind newline_record_blocker_core nrb_checker u_nrb_checker (.*);

/* sim/newline_record_blocker_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// newline_record_blocker_core_tb
// Self-checking bench for the newline to fixed-length record blocker.
// ----------------------------------------------------------------------------
// A stimulus process queues request beats (data bytes, end of input, table
// writes) in phases, each under its own record length and translate setting.
// A clocked driver feeds them to the slave port with random gaps and runs
// every accepted beat through an in-bench model of the blocker to queue the
// output beat it owes. A clocked monitor takes output beats under random
// backpressure, with a few long holds, and compares them field by field.
// ----------------------------------------------------------------------------
module newline_record_blocker_core_tb;

    localparam int ItemTarget = 1450;
    localparam int IdleLimit  = 3000;
    localparam int DrainCycles = 8;

    typedef struct packed {
        nrb_pkg::t_req kind;
        logic [7:0]    val;
        logic [7:0]    idx;
    } t_req_beat;

    typedef struct packed {
        logic [7:0]  ch;
        logic [12:0] reps;
        logic        rec_end;
        logic        eoi;
        logic [31:0] trunc;
    } t_rec_beat;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic        i_cfg_idx       = nrb_pkg::CFG_REC_LEN;
    logic [12:0] i_cfg_wdata     = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata  = '0;
    logic [1:0]  i_s_axis_tuser  = nrb_pkg::REQ_DATA;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [55:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        o_m_axis_tuser;

    newline_record_blocker_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // settings as last written, and the model's record state
    logic [12:0]    cfg_len  = nrb_pkg::RecLenReset;
    bit             cfg_xlat = 1'b0;
    logic [12:0]    m_column = '0;
    nrb_pkg::t_mode m_mode   = nrb_pkg::MODE_FILL;
    logic [31:0]    m_trunc  = '0;
    logic [7:0]     m_table [256];

    t_req_beat in_pending [$];
    t_rec_beat out_due [$];
    bit        gen_written [256];
    int        gen_items  = 0;
    int        mismatches = 0;

    function automatic logic [12:0] eff_rec_len();
        if (cfg_len == 0) return 13'd1;
        if (cfg_len > nrb_pkg::MaxRecLen) return 13'(nrb_pkg::MaxRecLen);
        return cfg_len;
    endfunction

    function automatic logic [7:0] xlat_byte(input logic [7:0] b);
        return cfg_xlat ? m_table[b] : b;
    endfunction

    function automatic bit block_record_step(input t_req_beat it, output t_rec_beat r);
        logic [12:0] len;
        logic [12:0] col_n;
        len = eff_rec_len();
        r = '0;
        case (it.kind)
            nrb_pkg::REQ_TBL: begin
                m_table[it.idx] = it.val;
                return 1'b0;
            end
            nrb_pkg::REQ_EOI: begin
                if (m_mode == nrb_pkg::MODE_FILL && m_column != 0) begin
                    if (m_trunc != '1) m_trunc++;
                    r.ch = xlat_byte(nrb_pkg::SpByte);
                    r.reps = (m_column < len) ? len - m_column : 13'd0;
                    r.rec_end = 1'b1;
                end
                r.eoi = 1'b1;
                r.trunc = m_trunc;
                m_trunc = '0;
                m_column = '0;
                m_mode = nrb_pkg::MODE_FILL;
                return 1'b1;
            end
            nrb_pkg::REQ_DATA: begin
                if (m_mode == nrb_pkg::MODE_FULL) begin
                    if (it.val == nrb_pkg::NlByte) begin
                        m_mode = nrb_pkg::MODE_FILL;
                    end else begin
                        if (m_trunc != '1) m_trunc++;
                        m_mode = nrb_pkg::MODE_SKIP;
                    end
                    return 1'b0;
                end
                if (m_mode == nrb_pkg::MODE_SKIP) begin
                    if (it.val == nrb_pkg::NlByte) m_mode = nrb_pkg::MODE_FILL;
                    return 1'b0;
                end
                r.trunc = m_trunc;
                if (it.val == nrb_pkg::NlByte) begin
                    r.ch = xlat_byte(nrb_pkg::SpByte);
                    r.reps = (m_column < len) ? len - m_column : 13'd0;
                    r.rec_end = 1'b1;
                    m_column = '0;
                    return 1'b1;
                end
                col_n = m_column + 13'd1;
                r.ch = xlat_byte(it.val);
                r.reps = 13'd1;
                if (col_n >= len || col_n == 0) begin
                    r.rec_end = 1'b1;
                    m_column = '0;
                    m_mode = nrb_pkg::MODE_FULL;
                end else begin
                    m_column = col_n;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ---------------- request driver ----------------
    t_req_beat cur_req;
    t_rec_beat pred_beat;
    logic      src_vld_n;
    int        src_wait = 0;
    int        src_sent = 0;
    bit        src_calm = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            src_wait = 0;
        end else begin
            src_vld_n = i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                if (block_record_step(cur_req, pred_beat)) out_due.push_back(pred_beat);
                src_vld_n = 1'b0;
                src_sent++;
                if (src_sent % 32 == 0) src_calm = ($urandom_range(0, 2) == 0);
            end
            if (!src_vld_n) begin
                if (src_wait != 0) begin
                    src_wait--;
                end else if (in_pending.size() != 0) begin
                    cur_req = in_pending.pop_front();
                    i_s_axis_tdata <= {cur_req.idx, cur_req.val};
                    i_s_axis_tuser <= cur_req.kind;
                    src_vld_n = 1'b1;
                    src_wait = src_calm ? 0 : $urandom_range(0, 10);
                end
            end
            i_s_axis_tvalid <= src_vld_n;
        end
    end

    // ---------------- output monitor ----------------
    t_rec_beat got_beat;
    t_rec_beat want_beat;
    int        snk_wait  = 0;
    int        hold_left = 0;
    int        out_beats = 0;
    bit        snk_calm  = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            snk_wait = 0;
            hold_left = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_beat = {o_m_axis_tdata[7:0], o_m_axis_tdata[20:8], o_m_axis_tlast,
                            o_m_axis_tuser, o_m_axis_tdata[52:21]};
                if (out_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: byte %h reps %0d end %b eoi %b trunc %0d",
                                 got_beat.ch, got_beat.reps, got_beat.rec_end,
                                 got_beat.eoi, got_beat.trunc);
                end else begin
                    want_beat = out_due.pop_front();
                    if (got_beat !== want_beat || o_m_axis_tdata[55:53] !== 3'd0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"beat %0d: expected byte %h reps %0d end %b eoi %b ",
                                      "trunc %0d, got byte %h reps %0d end %b eoi %b ",
                                      "trunc %0d pad %b"}, out_beats,
                                     want_beat.ch, want_beat.reps, want_beat.rec_end,
                                     want_beat.eoi, want_beat.trunc,
                                     got_beat.ch, got_beat.reps, got_beat.rec_end,
                                     got_beat.eoi, got_beat.trunc, o_m_axis_tdata[55:53]);
                    end
                end
                out_beats++;
                if (out_beats % 32 == 0) snk_calm = ($urandom_range(0, 2) == 0);
                snk_wait = snk_calm ? 0 : $urandom_range(0, 10);
                // long hold so the pipeline backs up into the slave side
                if (out_beats % 400 == 200) hold_left = 150;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (snk_wait != 0) begin
                snk_wait--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------- watchdog ----------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------- stimulus ----------------
    task automatic push_item(input nrb_pkg::t_req kind, input logic [7:0] val,
                             input logic [7:0] idx);
        t_req_beat it;
        it.kind = kind;
        it.val = val;
        it.idx = idx;
        in_pending.push_back(it);
        if (kind == nrb_pkg::REQ_TBL) gen_written[idx] = 1'b1;
        gen_items++;
    endtask

    task automatic push_data(input logic [7:0] b);
        push_item(nrb_pkg::REQ_DATA, b, 8'($urandom_range(0, 255)));
    endtask

    task automatic push_eoi();
        push_item(nrb_pkg::REQ_EOI, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic push_tbl(input logic [7:0] idx, input logic [7:0] val);
        push_item(nrb_pkg::REQ_TBL, val, idx);
    endtask

    // record text: no newline, and only written table entries when translating
    function automatic logic [7:0] pick_text();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == nrb_pkg::NlByte || (cfg_xlat && !gen_written[b]));
        return b;
    endfunction

    task automatic wait_idle();
        while (in_pending.size() != 0 || i_s_axis_tvalid || out_due.size() != 0)
            @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic cfg_write(input nrb_pkg::t_cfg_idx idx, input logic [12:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        if (idx == nrb_pkg::CFG_REC_LEN) cfg_len = val;
        else cfg_xlat = val[0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int          r;
        int          rec;
        int          phase_end;
        logic [12:0] len_pick;
        logic [12:0] eff;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: length 80, no translation
        push_eoi();
        push_data(8'h00);
        push_data(8'hFF);
        push_data(nrb_pkg::NlByte);
        push_data("a");
        push_eoi();
        push_tbl(nrb_pkg::SpByte, 8'h2E);
        push_tbl(8'h41, 8'hC3);
        push_tbl(8'hFF, 8'h00);
        wait_idle();
        cfg_write(nrb_pkg::CFG_REC_LEN, 13'd2);
        push_data("x");
        push_data("y");
        push_data(nrb_pkg::NlByte);   // newline after full record is swallowed
        push_data("p");
        push_data("q");
        push_data("s");               // overlong line, rest dropped
        push_data(nrb_pkg::NlByte);
        push_data("u");
        push_data("v");
        push_eoi();                   // complete record at end, not truncated
        wait_idle();
        cfg_write(nrb_pkg::CFG_REC_LEN, 13'd8);
        push_data("a");
        push_data("b");
        push_data("c");
        wait_idle();
        cfg_write(nrb_pkg::CFG_REC_LEN, 13'd0);
        push_data(nrb_pkg::NlByte);   // column already past length: zero pad
        wait_idle();
        cfg_write(nrb_pkg::CFG_REC_LEN, 13'd8);
        push_data("d");
        push_data("e");
        wait_idle();
        cfg_write(nrb_pkg::CFG_REC_LEN, 13'd1);
        push_eoi();
        wait_idle();
        cfg_write(nrb_pkg::CFG_REC_LEN, 13'h1FFF);
        cfg_write(nrb_pkg::CFG_XLAT_EN, 13'd1);
        push_data(8'h41);
        push_data(8'hFF);
        push_data(nrb_pkg::NlByte);
        push_eoi();

        while (gen_items < ItemTarget) begin
            wait_idle();
            r = $urandom_range(0, 19);
            case (r)
                0:       len_pick = 13'd0;
                1:       len_pick = 13'(nrb_pkg::MaxRecLen);
                2:       len_pick = 13'h1FFF;
                3, 4, 5: len_pick = 13'($urandom_range(13, 120));
                default: len_pick = 13'($urandom_range(1, 12));
            endcase
            cfg_write(nrb_pkg::CFG_REC_LEN, len_pick);
            cfg_write(nrb_pkg::CFG_XLAT_EN, 13'($urandom_range(0, 1)));
            if (cfg_xlat) begin
                if (!gen_written[nrb_pkg::SpByte])
                    push_tbl(nrb_pkg::SpByte, 8'($urandom_range(0, 255)));
                repeat (4) push_tbl(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
            eff = eff_rec_len();
            phase_end = gen_items + $urandom_range(30, 120);
            while (gen_items < phase_end) begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    push_tbl(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end else if (r < 9) begin
                    push_eoi();
                end else if (r < 15) begin
                    if ($urandom_range(0, 2) == 0) push_data(nrb_pkg::NlByte);
                    else push_data(pick_text());
                end else begin
                    rec = (eff > 24) ? $urandom_range(0, 24) : $urandom_range(0, eff + 2);
                    repeat (rec) push_data(pick_text());
                    if ($urandom_range(0, 9) != 0) push_data(nrb_pkg::NlByte);
                end
            end
        end

        wait_idle();
        mismatches += out_due.size();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
